>>> hdl/srof_pkg.sv
// ----------------------------------------------------------------------------
// srof_pkg: shared definitions for the sliding rank-order filter
// Register map, item opcodes, control state codes and the per-cell
// control bundle used by the cell row.
// ----------------------------------------------------------------------------
package srof_pkg;

  // Default sizes
  localparam int MAX_WINDOW_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 24;

  // Configuration register widths and reset values
  localparam int LEN_BITS  = 7;
  localparam int RANK_BITS = 6;
  localparam int CFG_ADDR_BITS = 1;
  localparam int CFG_DATA_BITS = 7;
  localparam logic [LEN_BITS-1:0]  LEN_RESET  = 7'd64;
  localparam logic [RANK_BITS-1:0] RANK_RESET = 6'd32;

  // Register indexes
  localparam logic [CFG_ADDR_BITS-1:0] REG_WINDOW_LENGTH = 1'b0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_SELECTED_RANK = 1'b1;

  // Item opcodes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_FILL = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_COUNT,
    S_SCAN,
    S_OUT
  } state_t;

  // Control bundle broadcast to every cell
  typedef struct packed {
    logic fill;   // write the sample into every slot
    logic push;   // write the sample into the addressed slot
    logic load;   // copy slot values into the tokens, clear counts
    logic step;   // move tokens one cell along the ring
    logic count;  // accumulate comparisons while stepping
  } cell_ctl_t;

endpackage

>>> hdl/srof_if.sv
// ----------------------------------------------------------------------------
// srof_if: item channels of the sliding rank-order filter
// Input channel carries an opcode and a sample, output channel the value
// at the selected rank. Valid/ready handshake on both.
// ----------------------------------------------------------------------------
interface srof_in_if #(
  parameter int SAMPLE_BITS = srof_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output op, output sample_in, input ready);
  modport sink   (input valid, input op, input sample_in, output ready);
endinterface

interface srof_out_if #(
  parameter int SAMPLE_BITS = srof_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] rank_value;

  modport source (output valid, output rank_value, input ready);
  modport sink   (input valid, input rank_value, output ready);
endinterface

>>> hdl/srof_cell.sv
// ----------------------------------------------------------------------------
// srof_cell: one slot of the window
// Holds one stored sample and one travelling token. The token carries a
// sample and the number of slots found below it and at or below it.
// ----------------------------------------------------------------------------
module srof_cell #(
  parameter int IDX         = 0,
  parameter int SW          = 6,
  parameter int CW          = 7,
  parameter int SAMPLE_BITS = srof_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  srof_pkg::cell_ctl_t           ctl,
  input  logic [SW-1:0]                 slot,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic signed [SAMPLE_BITS-1:0] nb_val,
  input  logic [CW-1:0]                 nb_lt,
  input  logic [CW-1:0]                 nb_le,
  output logic signed [SAMPLE_BITS-1:0] tok_val,
  output logic [CW-1:0]                 tok_lt,
  output logic [CW-1:0]                 tok_le
);

  logic signed [SAMPLE_BITS-1:0] value;

  // Store the sample on a fill, or on a push addressed to this slot
  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
    end else if (ctl.fill || (ctl.push && (slot == SW'(IDX)))) begin
      value <= sample;
    end
  end

  // Load the token from the slot, or take the neighbour's and compare
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      tok_val <= value;
      tok_lt  <= '0;
      tok_le  <= '0;
    end else if (ctl.step) begin
      tok_val <= nb_val;
      if (ctl.count) begin
        tok_lt <= nb_lt + CW'(value <  nb_val);
        tok_le <= nb_le + CW'(value <= nb_val);
      end else begin
        tok_lt <= nb_lt;
        tok_le <= nb_le;
      end
    end
  end

endmodule

>>> hdl/sliding_rank_order_filter_core.sv
// ----------------------------------------------------------------------------
// sliding_rank_order_filter_core: running rank-order (median) filter
// Keeps the last window_length samples and returns the one at a chosen
// sorted position after each item.
// ----------------------------------------------------------------------------
// Each slot of the window sits in a cell of a row; the cells of the active
// window form a ring. A push writes its slot, then every cell's sample sets
// off round the ring as a token, gathering how many slots lie below it and
// at or below it; after n steps (n the effective window length) each token
// is home with its rank, and the tokens are then checked as they pass cell 0
// until the one holding the selected rank is found. The next item is taken
// only after that result has been loaded into the output register, so a
// push is finished before another item is accepted. A fill item goes
// straight to the output state, and the next item is likewise taken once
// its result has been loaded into the output register.
// The result sits in an output register, so a stalled consumer only holds
// off the next result, not the work already under way. Length 0 acts as 1,
// lengths above MAX_WINDOW act as MAX_WINDOW, and a rank at or beyond the
// length selects the largest sample.
// ----------------------------------------------------------------------------
module sliding_rank_order_filter_core #(
  parameter int MAX_WINDOW  = srof_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = srof_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  srof_in_if.sink                            samples,
  srof_out_if.source                         results,
  input  logic                               cfg_wen,
  input  logic [srof_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [srof_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);

  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int SW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  // Configuration
  logic [srof_pkg::LEN_BITS-1:0]  win_len;
  logic [srof_pkg::RANK_BITS-1:0] sel_rank;

  // Sequencer
  srof_pkg::state_t    state, state_next;
  logic [CW-1:0]       cnt, cnt_next;
  logic [CW-1:0]       n_item, r_item;
  logic [SW-1:0]       oldest, slot_eff, oldest_next;
  logic signed [SAMPLE_BITS-1:0] result, result_next;
  logic signed [SAMPLE_BITS-1:0] out_data;
  logic                out_valid;
  logic                load_out;
  logic                accept;
  logic                hit;
  srof_pkg::cell_ctl_t ctl;

  // Effective length and rank
  logic [31:0] len32, n32, r32, slot_inc;
  logic [CW-1:0] n_cur, r_cur;

  // Token ring
  logic signed [SAMPLE_BITS-1:0] tok_val [MAX_WINDOW];
  logic [CW-1:0]                 tok_lt  [MAX_WINDOW];
  logic [CW-1:0]                 tok_le  [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] nb_val  [MAX_WINDOW];
  logic [CW-1:0]                 nb_lt   [MAX_WINDOW];
  logic [CW-1:0]                 nb_le   [MAX_WINDOW];

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      win_len  <= srof_pkg::LEN_RESET;
      sel_rank <= srof_pkg::RANK_RESET;
    end else if (cfg_wen) begin
      unique case (cfg_addr)
        srof_pkg::REG_WINDOW_LENGTH: win_len  <= cfg_wdata[srof_pkg::LEN_BITS-1:0];
        srof_pkg::REG_SELECTED_RANK: sel_rank <= cfg_wdata[srof_pkg::RANK_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Clamp length and saturate rank; wrap the write position
  always_comb begin
    len32 = 32'(win_len);
    if (len32 == 32'd0) begin
      n32 = 32'd1;
    end else if (len32 > 32'(MAX_WINDOW)) begin
      n32 = 32'(MAX_WINDOW);
    end else begin
      n32 = len32;
    end
    r32 = (32'(sel_rank) >= n32) ? (n32 - 32'd1) : 32'(sel_rank);
    n_cur = CW'(n32);
    r_cur = CW'(r32);
    slot_eff = (32'(oldest) >= n32) ? '0 : oldest;
    slot_inc = 32'(slot_eff) + 32'd1;
    oldest_next = (slot_inc >= n32) ? '0 : SW'(slot_inc);
  end

  assign accept = samples.valid && samples.ready;
  assign hit    = (tok_lt[0] <= r_item) && (r_item < tok_le[0]);

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srof_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and cell control
  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    result_next     = result;
    ctl             = '0;
    load_out        = 1'b0;
    samples.ready   = 1'b0;
    unique case (state)
      srof_pkg::S_IDLE: begin
        samples.ready = 1'b1;
        if (samples.valid) begin
          if (samples.op == srof_pkg::OP_FILL) begin
            ctl.fill    = 1'b1;
            result_next = samples.sample_in;
            state_next  = srof_pkg::S_OUT;
          end else begin
            ctl.push   = 1'b1;
            state_next = srof_pkg::S_LOAD;
          end
        end
      end
      srof_pkg::S_LOAD: begin
        ctl.load   = 1'b1;
        cnt_next   = '0;
        state_next = srof_pkg::S_COUNT;
      end
      srof_pkg::S_COUNT: begin
        ctl.step  = 1'b1;
        ctl.count = 1'b1;
        if (cnt == n_item - CW'(1)) begin
          cnt_next   = '0;
          state_next = srof_pkg::S_SCAN;
        end else begin
          cnt_next = cnt + CW'(1);
        end
      end
      srof_pkg::S_SCAN: begin
        if (hit || (cnt == n_item - CW'(1))) begin
          result_next = tok_val[0];
          state_next  = srof_pkg::S_OUT;
        end else begin
          ctl.step = 1'b1;
          cnt_next = cnt + CW'(1);
        end
      end
      srof_pkg::S_OUT: begin
        if (!out_valid || results.ready) begin
          load_out   = 1'b1;
          state_next = srof_pkg::S_IDLE;
        end
      end
      default: state_next = srof_pkg::S_IDLE;
    endcase
  end

  // Step counter, latched length and rank, result
  always_ff @(posedge clk) begin
    cnt    <= cnt_next;
    result <= result_next;
    if (accept) begin
      n_item <= n_cur;
      r_item <= r_cur;
    end
  end

  // Advance the write position
  always_ff @(posedge clk) begin
    if (rst) begin
      oldest <= '0;
    end else if (accept) begin
      oldest <= (samples.op == srof_pkg::OP_FILL) ? '0 : oldest_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= result;
    end
  end

  assign results.valid      = out_valid;
  assign results.rank_value = out_data;

  // Cell row; the cell at n-1 closes the ring back to cell 0
  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    if (i == MAX_WINDOW - 1) begin : g_last
      assign nb_val[i] = tok_val[0];
      assign nb_lt[i]  = tok_lt[0];
      assign nb_le[i]  = tok_le[0];
    end else begin : g_mid
      logic wrap;
      assign wrap      = (n_item == CW'(i + 1));
      assign nb_val[i] = wrap ? tok_val[0] : tok_val[i+1];
      assign nb_lt[i]  = wrap ? tok_lt[0]  : tok_lt[i+1];
      assign nb_le[i]  = wrap ? tok_le[0]  : tok_le[i+1];
    end

    srof_cell #(
      .IDX         (i),
      .SW          (SW),
      .CW          (CW),
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .slot    (slot_eff),
      .sample  (samples.sample_in),
      .nb_val  (nb_val[i]),
      .nb_lt   (nb_lt[i]),
      .nb_le   (nb_le[i]),
      .tok_val (tok_val[i]),
      .tok_lt  (tok_lt[i]),
      .tok_le  (tok_le[i])
    );
  end

  // Step counter stays inside the window while circulating
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (state == srof_pkg::S_COUNT || state == srof_pkg::S_SCAN) |-> (cnt < n_item))
    else $error("ring step counter ran past the window length");

  // A fill answers its own value straight away
  a_fill_result: assert property (@(posedge clk) disable iff (rst)
    (accept && samples.op == srof_pkg::OP_FILL) |=>
      (state == srof_pkg::S_OUT && result == $past(samples.sample_in)))
    else $error("fill item did not return its value");

  // A push always circulates the tokens before answering
  a_push_load: assert property (@(posedge clk) disable iff (rst)
    (accept && samples.op == srof_pkg::OP_PUSH) |=> (state == srof_pkg::S_LOAD))
    else $error("push item skipped the token load");

  // A new result appears only from the output state
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(results.valid) |-> ($past(state) == srof_pkg::S_OUT))
    else $error("result raised outside the output state");

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: sliding rank-order filter core
// Streams push and fill items through the filter under random valid/ready
// gaps and one long output stall. Register settings are changed between
// phases while the core is idle. A scoreboard keeps its own copy of the
// window and predicts the ranked value of every item; each result is
// compared in order with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import srof_pkg::*;

  localparam int WIN          = MAX_WINDOW_DEF;
  localparam int SW           = SAMPLE_BITS_DEF;
  localparam int RANDOM_ITEMS = 1100;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 2 * WIN + 20;

  typedef logic signed [SW-1:0] sample_t;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};

  // Window copy, register copy and the queue of predicted ranked values
  class rank_order_scoreboard;
    sample_t          slots[WIN];
    int unsigned      write_pos;
    logic [LEN_BITS-1:0]  length_reg;
    logic [RANK_BITS-1:0] rank_reg;
    sample_t          expected_ranks[$];
    int               errors;
    int               compared;
    int               pushes;
    int               fills;

    function new();
      foreach (slots[i]) slots[i] = '0;
      write_pos  = 0;
      length_reg = LEN_RESET;
      rank_reg   = RANK_RESET;
      errors     = 0;
      compared   = 0;
      pushes     = 0;
      fills      = 0;
    endfunction

    function void write_reg(logic [CFG_ADDR_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
      if (idx == REG_WINDOW_LENGTH) begin
        length_reg = data[LEN_BITS-1:0];
      end else begin
        rank_reg = data[RANK_BITS-1:0];
      end
    endfunction

    // Clamp the length register into 1..WIN
    function int unsigned active_length();
      int unsigned n;
      n = length_reg;
      if (n == 0) n = 1;
      if (n > WIN) n = WIN;
      return n;
    endfunction

    // Value at sorted position r among slots 0..n-1, ties resolved by count
    function sample_t rank_of_window(int unsigned n, int unsigned r);
      int unsigned below;
      int unsigned at_or_below;
      for (int i = 0; i < n; i++) begin
        below       = 0;
        at_or_below = 0;
        for (int j = 0; j < n; j++) begin
          if (slots[j] < slots[i]) below++;
          if (slots[j] <= slots[i]) at_or_below++;
        end
        if (below <= r && r < at_or_below) return slots[i];
      end
      return slots[0];
    endfunction

    // Apply one accepted item and queue the value it should produce
    function void note_item(logic op, sample_t x);
      int unsigned n;
      int unsigned r;
      n = active_length();
      r = (rank_reg >= n) ? n - 1 : rank_reg;
      if (op == OP_FILL) begin
        foreach (slots[i]) slots[i] = x;
        write_pos = 0;
        expected_ranks.push_back(x);
        fills++;
      end else begin
        if (write_pos >= n) write_pos = 0;
        slots[write_pos] = x;
        write_pos++;
        if (write_pos >= n) write_pos = 0;
        expected_ranks.push_back(rank_of_window(n, r));
        pushes++;
      end
    endfunction

    function void check_item(sample_t got);
      sample_t want;
      if (expected_ranks.size() == 0) begin
        $display("%0t ns: result with no item outstanding, expected none, got %0d",
                 $time, got);
        errors++;
        return;
      end
      want = expected_ranks.pop_front();
      compared++;
      if (got !== want) begin
        $display("%0t ns: rank_value mismatch, expected %0d, got %0d", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst;
  logic                     cfg_wen;
  logic [CFG_ADDR_BITS-1:0] cfg_addr;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;

  srof_in_if  #(.SAMPLE_BITS(SW)) sample_ch ();
  srof_out_if #(.SAMPLE_BITS(SW)) result_ch ();

  rank_order_scoreboard rank_check = new();

  // Shared between the stimulus and the result side
  logic rx_no_idle;
  int   hold_requests;
  int   holds_done;
  int   hold_left;
  bit   tx_no_idle;
  int   items_sent;
  int   settings_used;

  sliding_rank_order_filter_core #(
    .MAX_WINDOW  (WIN),
    .SAMPLE_BITS (SW)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .samples   (sample_ch),
    .results   (result_ch),
    .cfg_wen   (cfg_wen),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Give up after a generous fixed time
  initial begin
    #4_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Result side: check accepted items, then choose ready for the next cycle
  initial begin
    result_ch.ready <= 1'b0;
    holds_done = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid && result_ch.ready) begin
        rank_check.check_item(result_ch.rank_value);
      end
      if (holds_done < hold_requests) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= rx_no_idle || ($urandom_range(99) >= 32);
      end
    end
  end

  function automatic sample_t pick_sample();
    case ($urandom_range(3))
      0, 1: return sample_t'($urandom);
      2: return sample_t'(int'($urandom_range(6)) - 3);
      default: begin
        case ($urandom_range(3))
          0: return SAMPLE_MAX;
          1: return SAMPLE_MIN;
          2: return '0;
          default: return '1;
        endcase
      end
    endcase
  endfunction

  // Offer one item, idling first at random; return at the accepting edge
  task automatic send_item(input logic op, input sample_t x);
    int gap;
    if (!tx_no_idle && $urandom_range(99) < 32) begin
      gap = ($urandom_range(7) == 0) ? $urandom_range(4, 40) : $urandom_range(1, 3);
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid     <= 1'b1;
    sample_ch.op        <= op;
    sample_ch.sample_in <= x;
    do @(posedge clk); while (!sample_ch.ready);
    rank_check.note_item(op, x);
    items_sent++;
  endtask

  // Drop valid and wait until every predicted result has been taken
  task automatic settle();
    sample_ch.valid <= 1'b0;
    while (rank_check.expected_ranks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_wen   <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    rank_check.write_reg(idx, data);
    cfg_wen <= 1'b0;
    @(posedge clk);
  endtask

  task automatic new_setting(input logic [CFG_DATA_BITS-1:0] len,
                             input logic [CFG_DATA_BITS-1:0] rank);
    settle();
    write_reg(REG_WINDOW_LENGTH, len);
    write_reg(REG_SELECTED_RANK, rank);
    settings_used++;
  endtask

  // Directed items: extremes, fills, short and clamped lengths, large ranks
  task automatic run_directed();
    // reset window of zeros, length 64, rank 32
    send_item(OP_PUSH, SAMPLE_MAX);
    send_item(OP_PUSH, SAMPLE_MIN);
    send_item(OP_FILL, SAMPLE_MIN);
    send_item(OP_PUSH, SAMPLE_MAX);
    send_item(OP_FILL, SAMPLE_MAX);
    send_item(OP_PUSH, -1);
    // length of one, rank saturates, push straight after the length write
    settle();
    write_reg(REG_WINDOW_LENGTH, 7'd1);
    settings_used++;
    send_item(OP_PUSH, 5);
    send_item(OP_PUSH, -3);
    send_item(OP_FILL, 7);
    // rank far beyond a short window, pushes with no fill after the change
    new_setting(7'd4, 7'd63);
    send_item(OP_PUSH, 1);
    send_item(OP_PUSH, 2);
    send_item(OP_PUSH, -2);
    send_item(OP_PUSH, 3);
    // rank changes take effect without a fill
    settle();
    write_reg(REG_SELECTED_RANK, 7'd0);
    send_item(OP_PUSH, 0);
    settle();
    write_reg(REG_SELECTED_RANK, 7'd2);
    send_item(OP_PUSH, 0);
    // length zero acts as one
    new_setting(7'd0, 7'd1);
    send_item(OP_FILL, 9);
    send_item(OP_PUSH, -9);
    // length above the maximum clamps, rank write with the top bit set
    new_setting(7'h7F, 7'h7F);
    send_item(OP_FILL, 100);
    send_item(OP_PUSH, -100);
    send_item(OP_PUSH, 4);
    new_setting(7'd64, 7'd32);
    send_item(OP_PUSH, SAMPLE_MAX);
    send_item(OP_PUSH, 0);
  endtask

  // Random phases: mostly short windows, most of them started by a fill
  task automatic run_random();
    int          target;
    int          phase;
    int          count;
    int unsigned len;
    int unsigned span;
    int unsigned rank;
    int          pick;
    target = items_sent + RANDOM_ITEMS;
    phase  = 0;
    while (items_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 70)      len = $urandom_range(1, 12);
      else if (pick < 85) len = $urandom_range(13, 40);
      else if (pick < 93) len = WIN;
      else                len = $urandom_range(0, 127);
      span = (len == 0) ? 1 : ((len > WIN) ? WIN : len);
      rank = ($urandom_range(1) == 0) ? $urandom_range(0, span + 1) : $urandom_range(0, 127);
      count = $urandom_range(20, 60);

      // hold the output back while the input keeps offering items
      if (phase == 3) begin
        len   = 4;
        rank  = 1;
        count = 60;
      end

      settle();
      if (phase != 3 && $urandom_range(4) == 0) begin
        write_reg(REG_SELECTED_RANK, rank[CFG_DATA_BITS-1:0]);
      end else begin
        write_reg(REG_WINDOW_LENGTH, len[CFG_DATA_BITS-1:0]);
        write_reg(REG_SELECTED_RANK, rank[CFG_DATA_BITS-1:0]);
      end
      settings_used++;

      tx_no_idle = (phase == 3) || (phase == 6);
      rx_no_idle <= (phase == 6);
      if (phase == 3) hold_requests <= hold_requests + 1;

      if ($urandom_range(99) < 85) send_item(OP_FILL, pick_sample());
      repeat (count) begin
        if ($urandom_range(99) < 4) send_item(OP_FILL, pick_sample());
        else                        send_item(OP_PUSH, pick_sample());
      end
      phase++;
    end
    tx_no_idle = 1'b0;
    rx_no_idle <= 1'b0;
  endtask

  // Main sequence
  initial begin
    rst                 <= 1'b1;
    cfg_wen             <= 1'b0;
    cfg_addr            <= REG_WINDOW_LENGTH;
    cfg_wdata           <= '0;
    sample_ch.valid     <= 1'b0;
    sample_ch.op        <= OP_PUSH;
    sample_ch.sample_in <= '0;
    rx_no_idle          <= 1'b0;
    hold_requests       <= 0;
    tx_no_idle    = 1'b0;
    items_sent    = 0;
    settings_used = 1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();
    run_random();

    // Drain, then watch for stray results
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (rank_check.expected_ranks.size() != 0) begin
      $display("%0t ns: results missing, expected %0d more, got none", $time,
               rank_check.expected_ranks.size());
      rank_check.errors++;
    end

    $display("Covered %0d pushes and %0d fills over %0d register settings,",
             rank_check.pushes, rank_check.fills, settings_used);
    $display("lengths 0 to 127, saturated ranks and a %0d-cycle output stall; %0d compared.",
             HOLD_CYCLES, rank_check.compared);
    if (rank_check.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
